// ----- hdl/deq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg
// Shared sizes, field layout, request codes, result codes and state codes of the
// double-ended queue unit.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int OP_W      = 4;
  localparam int IDX_W     = 11;
  localparam int DATA_W    = 32;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 11;

  localparam int IN_OP_LSB  = 0;
  localparam int IN_IDX_LSB = IN_OP_LSB + OP_W;
  localparam int IN_VAL_LSB = IN_IDX_LSB + IDX_W;
  localparam int IN_BITS    = IN_VAL_LSB + DATA_W;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  localparam int OUT_BITS    = DATA_W + STAT_W + CNT_OUT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int SUM_W = ((CMP_W > ADDR_W) ? CMP_W : ADDR_W) + 1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_TAIL = 4'd0,
    OP_PUSH_HEAD = 4'd1,
    OP_POP_TAIL  = 4'd2,
    OP_POP_HEAD  = 4'd3,
    OP_READ      = 4'd4,
    OP_WRITE     = 4'd5,
    OP_INSERT    = 4'd6,
    OP_ERASE     = 4'd7,
    OP_CLEAR     = 4'd8
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_ERASE_RD = 6'b000010,
    S_SHIFT_DN = 6'b000100,
    S_SHIFT_UP = 6'b001000,
    S_INS_PUT  = 6'b010000,
    S_DONE     = 6'b100000
  } state_t;

endpackage
`default_nettype wire

// ----- hdl/double_ended_queue_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Double-ended queue of 32-bit words in a circular single-port-write,
// single-port-read synchronous memory.
//
// Requests arrive on the s_ stream (operation, index, value) and every
// request gives exactly one result on the m_ stream (data, status, count).
// One request is worked at a time; s_tready is high while the unit is idle
// and out of reset. For push, pop, read, write, clear and an insert at the
// back, the memory is accessed on acceptance and the result then goes to
// the output register once it is free. Insert before position i first moves
// the count - i elements from the back up, then writes the value; erase at
// position i reads the word and moves the count - 1 - i elements behind it
// down, moving one element per cycle through the memory's write port.
// Reset empties the queue and drops a pending result; memory contents are
// left as they are and are never read before written. When the receiver
// stalls, the result holds in the output register and the unit takes the
// next request; a following result waits until the register is taken.
// ----------------------------------------------------------------------------
module double_ended_queue_unit
  import deq_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // operation [3:0], index [14:4], value [46:15], zero pad above
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // data [31:0], status [33:32], count [44:34], zero pad above
  output logic [OUT_TDATA_W-1:0]      m_tdata
);

  logic [DATA_W-1:0] store_mem [CAPACITY];
  logic [DATA_W-1:0] rd_data;

  state_t            state;
  logic [ADDR_W-1:0] front;
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] sh_slot;
  logic [CNT_W-1:0]  rem;
  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] res_data;
  status_t           res_status;
  logic              res_from_mem;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  logic              acc;
  logic [OP_W-1:0]   in_op;
  logic [IDX_W-1:0]  in_idx;
  logic [DATA_W-1:0] in_val;
  logic [CMP_W-1:0]  idx_c;
  logic [CMP_W-1:0]  cnt_c;
  logic              full;
  logic              empty;
  logic              idx_lt;
  logic              idx_le;
  logic [ADDR_W-1:0] slot_cnt;
  logic [ADDR_W-1:0] slot_idx;
  logic [DATA_W-1:0] out_data;
  logic              out_load;

  status_t           dec_status;
  logic              dec_from_mem;
  state_t            dec_state;

  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                 input logic [SUM_W-1:0]  off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + off;
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] slot_dec(input logic [ADDR_W-1:0] s);
    return (s == '0) ? ADDR_W'(CAPACITY - 1) : s - 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_inc(input logic [ADDR_W-1:0] s);
    return (s == ADDR_W'(CAPACITY - 1)) ? '0 : s + 1'b1;
  endfunction

  assign s_tready = (state == S_IDLE) && !rst;
  assign acc      = s_tvalid & s_tready;
  assign in_op    = s_tdata[IN_OP_LSB +: OP_W];
  assign in_idx   = s_tdata[IN_IDX_LSB +: IDX_W];
  assign in_val   = s_tdata[IN_VAL_LSB +: DATA_W];

  assign idx_c    = CMP_W'(in_idx);
  assign cnt_c    = CMP_W'(count);
  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);
  assign idx_lt   = (idx_c < cnt_c);
  assign idx_le   = (idx_c <= cnt_c);
  assign slot_cnt = wrap_add(front, SUM_W'(count));
  assign slot_idx = wrap_add(front, SUM_W'(in_idx));
  assign out_data = res_from_mem ? rd_data : res_data;
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    dec_status   = ST_OK;
    dec_from_mem = 1'b0;
    dec_state    = S_DONE;
    case (in_op)
      OP_PUSH_TAIL, OP_PUSH_HEAD: begin
        if (full) begin
          dec_status = ST_FULL;
        end
      end
      OP_POP_TAIL, OP_POP_HEAD: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_from_mem = 1'b1;
        end
      end
      OP_READ: begin
        if (idx_lt) begin
          dec_from_mem = 1'b1;
        end else begin
          dec_status = ST_RANGE;
        end
      end
      OP_WRITE: begin
        if (!idx_lt) begin
          dec_status = ST_RANGE;
        end
      end
      OP_INSERT: begin
        if (!idx_le) begin
          dec_status = ST_RANGE;
        end else if (full) begin
          dec_status = ST_FULL;
        end else if (idx_c != cnt_c) begin
          dec_state = S_SHIFT_UP;
        end
      end
      OP_ERASE: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else if (!idx_lt) begin
          dec_status = ST_RANGE;
        end else begin
          dec_state = S_ERASE_RD;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sh_slot;
    mem_wdata = val_r;
    mem_re    = 1'b0;
    mem_raddr = sh_slot;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (in_op)
            OP_PUSH_TAIL: begin
              mem_we    = !full;
              mem_waddr = slot_cnt;
              mem_wdata = in_val;
            end
            OP_PUSH_HEAD: begin
              mem_we    = !full;
              mem_waddr = slot_dec(front);
              mem_wdata = in_val;
            end
            OP_POP_TAIL: begin
              mem_re    = !empty;
              mem_raddr = slot_dec(slot_cnt);
            end
            OP_POP_HEAD: begin
              mem_re    = !empty;
              mem_raddr = front;
            end
            OP_READ: begin
              mem_re    = idx_lt;
              mem_raddr = slot_idx;
            end
            OP_WRITE: begin
              mem_we    = idx_lt;
              mem_waddr = slot_idx;
              mem_wdata = in_val;
            end
            OP_INSERT: begin
              if (idx_le && !full) begin
                if (idx_c == cnt_c) begin
                  mem_we    = 1'b1;
                  mem_waddr = slot_idx;
                  mem_wdata = in_val;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = slot_dec(slot_cnt);
                end
              end
            end
            OP_ERASE: begin
              mem_re    = !empty && idx_lt;
              mem_raddr = slot_idx;
            end
            default: begin
            end
          endcase
        end
      end
      S_ERASE_RD: begin
        mem_re    = (rem != '0);
        mem_raddr = slot_inc(sh_slot);
      end
      S_SHIFT_DN: begin
        mem_we    = 1'b1;
        mem_wdata = rd_data;
        mem_re    = (rem != CNT_W'(1));
        mem_raddr = slot_inc(slot_inc(sh_slot));
      end
      S_SHIFT_UP: begin
        mem_we    = 1'b1;
        mem_wdata = rd_data;
        mem_re    = (rem != CNT_W'(1));
        mem_raddr = slot_dec(slot_dec(sh_slot));
      end
      S_INS_PUT: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= store_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc) begin
            res_status   <= dec_status;
            res_data     <= '0;
            res_from_mem <= dec_from_mem;
            state        <= dec_state;
            case (in_op)
              OP_PUSH_TAIL: begin
                if (!full) begin
                  count <= count + 1'b1;
                end
              end
              OP_PUSH_HEAD: begin
                if (!full) begin
                  front <= slot_dec(front);
                  count <= count + 1'b1;
                end
              end
              OP_POP_TAIL: begin
                if (!empty) begin
                  count <= count - 1'b1;
                end
              end
              OP_POP_HEAD: begin
                if (!empty) begin
                  front <= slot_inc(front);
                  count <= count - 1'b1;
                end
              end
              OP_INSERT: begin
                if (idx_le && !full) begin
                  if (idx_c == cnt_c) begin
                    count <= count + 1'b1;
                  end else begin
                    sh_slot <= slot_cnt;
                    rem     <= CNT_W'(cnt_c - idx_c);
                    val_r   <= in_val;
                  end
                end
              end
              OP_ERASE: begin
                if (!empty && idx_lt) begin
                  sh_slot <= slot_idx;
                  rem     <= CNT_W'(cnt_c - idx_c - 1'b1);
                end
              end
              OP_CLEAR: begin
                front <= '0;
                count <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_ERASE_RD: begin
          res_data <= rd_data;
          if (rem == '0) begin
            count <= count - 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_SHIFT_DN;
          end
        end
        S_SHIFT_DN: begin
          sh_slot <= slot_inc(sh_slot);
          if (rem == CNT_W'(1)) begin
            count <= count - 1'b1;
            state <= S_DONE;
          end else begin
            rem <= rem - 1'b1;
          end
        end
        S_SHIFT_UP: begin
          sh_slot <= slot_dec(sh_slot);
          if (rem == CNT_W'(1)) begin
            state <= S_INS_PUT;
          end else begin
            rem <= rem - 1'b1;
          end
        end
        S_INS_PUT: begin
          count <= count + 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= OUT_TDATA_W'({CNT_OUT_W'(count), res_status, out_data});
    end
  end

endmodule
`default_nettype wire
